### rtl/core/nha_pkg.sv
// nha_pkg: shared types, codes and sizes of the named handle allocator
// used by nha_engine, named_handle_allocator_top and nha_checker; no dependencies
package nha_pkg;

   // sizes
   localparam int ID_W    = 8;
   localparam int MAX_IDS = 1 << ID_W;
   localparam int CNT_W   = ID_W + 1;
   localparam int NAME_W  = 64;
   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;

   // stream packing
   localparam int REQ_BITS    = NAME_W + VALUE_W + ID_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = STAT_W + ID_W + VALUE_W + CNT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // request opcodes
   typedef enum logic [OP_W-1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_QUERY      = 2'd2,
      OP_GET        = 2'd3
   } nha_op_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_IN_USE    = 2'd1,
      STAT_LIMIT     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } nha_status_type;

   // engine sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_GET,
      S_DONE
   } nha_state_type;

   typedef struct packed {
      nha_op_type         op;
      logic [NAME_W-1:0]  name_hash;
      logic [VALUE_W-1:0] obj_value;
      logic [ID_W-1:0]    slot_id;
   } nha_req_type;

   typedef struct packed {
      nha_status_type     status;
      logic [ID_W-1:0]    handle_id;
      logic [VALUE_W-1:0] value_out;
      logic [CNT_W-1:0]   high_water;
   } nha_rsp_type;

endpackage

### rtl/core/nha_engine.sv
// nha_engine: name, value and free-id memories with the lookup and update sequencer
// depends on nha_pkg
module nha_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  nha_pkg::nha_req_type req,
   output logic                res_valid,
   input  logic                res_ready,
   output nha_pkg::nha_rsp_type res
);
   import nha_pkg::*;

   nha_state_type state_ff, state_in;
   nha_req_type   req_ff;
   nha_rsp_type   res_ff, res_in;

   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] next_fresh_ff, next_fresh_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [ID_W-1:0]  cmp_id_ff, cmp_id_in;
   logic [MAX_IDS-1:0] valid_ff;

   // memories, registered read
   logic [NAME_W-1:0]  name_mem  [MAX_IDS];
   logic [VALUE_W-1:0] value_mem [MAX_IDS];
   logic [ID_W-1:0]    stack_mem [MAX_IDS];

   logic [ID_W-1:0]    rd_addr;
   logic [NAME_W-1:0]  name_rd_ff;
   logic [VALUE_W-1:0] value_rd_ff;
   logic [ID_W-1:0]    stack_rd_addr;
   logic [ID_W-1:0]    stack_rd_ff;

   logic            slot_we;
   logic [ID_W-1:0] slot_waddr;
   logic            valid_clr;
   logic            stack_we;

   logic hit;
   logic miss;
   logic get_ok;

   // scan compare stage: data read last cycle against the request name
   assign hit = (state_ff == S_SCAN) && cmp_vld_ff && valid_ff[cmp_id_ff]
                && (name_rd_ff == req_ff.name_hash);
   assign miss = (state_ff == S_SCAN) && !cmp_vld_ff && (scan_ff >= next_fresh_ff);
   assign get_ok = (req_ff.slot_id != '0) && ({1'b0, req_ff.slot_id} < next_fresh_ff);

   // top of the free stack is read every cycle
   assign stack_rd_addr = free_count_ff[ID_W-1:0] - ID_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req.op == OP_GET) ? S_GET : S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               state_in = S_DONE;
            end else if (miss) begin
               if (req_ff.op == OP_REGISTER && free_count_ff != '0) begin
                  state_in = S_ALLOC;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_ALLOC: state_in = S_DONE;
         S_GET:   state_in = S_DONE;
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control and result
   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      res_valid     = (state_ff == S_DONE);
      res           = res_ff;
      res.high_water = next_fresh_ff;
      res_in        = res_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = 1'b0;
      cmp_id_in     = cmp_id_ff;
      free_count_in = free_count_ff;
      next_fresh_in = next_fresh_ff;
      rd_addr       = scan_ff[ID_W-1:0];
      slot_we       = 1'b0;
      slot_waddr    = next_fresh_ff[ID_W-1:0];
      valid_clr     = 1'b0;
      stack_we      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // a get reads its slot right away; a lookup starts at the first id
            rd_addr = req.slot_id;
            scan_in = CNT_W'(1);
         end
         S_SCAN: begin
            // issue one read per cycle over every id handed out so far
            if (scan_ff < next_fresh_ff) begin
               scan_in    = scan_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_id_in  = scan_ff[ID_W-1:0];
            end
            res_in.high_water = '0;
            if (hit) begin
               res_in.handle_id = cmp_id_ff;
               res_in.value_out = '0;
               res_in.status    = STAT_OK;
               case (req_ff.op)
                  OP_REGISTER: res_in.status = STAT_IN_USE;
                  OP_UNREGISTER: begin
                     valid_clr = 1'b1;
                     if (free_count_ff < CNT_W'(MAX_IDS)) begin
                        stack_we      = 1'b1;
                        free_count_in = free_count_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: res_in.value_out = value_rd_ff;
                  default: begin
                     res_in.status    = STAT_NOT_FOUND;
                     res_in.handle_id = '0;
                  end
               endcase
            end else if (miss) begin
               res_in.handle_id = '0;
               res_in.value_out = '0;
               res_in.status    = STAT_NOT_FOUND;
               if (req_ff.op == OP_REGISTER) begin
                  if (free_count_ff != '0) begin
                     // freed id comes from the stack next cycle
                     res_in.status = STAT_OK;
                  end else if (next_fresh_ff < CNT_W'(MAX_IDS)) begin
                     slot_we          = 1'b1;
                     slot_waddr       = next_fresh_ff[ID_W-1:0];
                     next_fresh_in    = next_fresh_ff + CNT_W'(1);
                     res_in.status    = STAT_OK;
                     res_in.handle_id = next_fresh_ff[ID_W-1:0];
                  end else begin
                     res_in.status = STAT_LIMIT;
                  end
               end
            end
         end
         S_ALLOC: begin
            // pop the most recently freed id
            free_count_in    = free_count_ff - CNT_W'(1);
            res_in.value_out = '0;
            if (stack_rd_ff == '0) begin
               res_in.status    = STAT_LIMIT;
               res_in.handle_id = '0;
            end else begin
               slot_we          = 1'b1;
               slot_waddr       = stack_rd_ff;
               res_in.status    = STAT_OK;
               res_in.handle_id = stack_rd_ff;
            end
         end
         S_GET: begin
            res_in.high_water = '0;
            if (get_ok) begin
               res_in.status    = STAT_OK;
               res_in.handle_id = req_ff.slot_id;
               res_in.value_out = valid_ff[req_ff.slot_id] ? value_rd_ff : '0;
            end else begin
               res_in.status    = STAT_NOT_FOUND;
               res_in.handle_id = '0;
               res_in.value_out = '0;
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_count_ff <= '0;
         next_fresh_ff <= CNT_W'(1);
         cmp_vld_ff    <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         next_fresh_ff <= next_fresh_in;
         cmp_vld_ff    <= cmp_vld_in;
         if (slot_we) begin
            valid_ff[slot_waddr] <= 1'b1;
         end else if (valid_clr) begin
            valid_ff[cmp_id_ff] <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      cmp_id_ff <= cmp_id_in;
      res_ff    <= res_in;
      if (req_valid && req_ready) begin
         req_ff <= req;
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (slot_we) begin
         name_mem[slot_waddr]  <= req_ff.name_hash;
         value_mem[slot_waddr] <= req_ff.obj_value;
      end
      if (stack_we) begin
         stack_mem[free_count_ff[ID_W-1:0]] <= cmp_id_ff;
      end
      name_rd_ff  <= name_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
      stack_rd_ff <= stack_mem[stack_rd_addr];
   end

endmodule

### rtl/core/named_handle_allocator_top.sv
// named_handle_allocator_top: stream ports and result register of the handle allocator
// depends on nha_pkg and nha_engine
//
// Usage:
//  One request on req_* (opcode in req_tuser) gives exactly one result on rsp_*.
//  Register binds a name hash to a freed id (last freed first) or to the next
//  fresh id; unregister frees the id; query looks a value up by name; get reads
//  a value by id. Every result carries the fresh-id high-water mark.
//  Requests are handled one at a time. A name lookup reads the name memory one
//  id per cycle over ids 1 to high_water-1. Register, unregister and query go
//  through the scan state, and through the alloc state when a freed id is
//  popped from the free stack, before the done state; get goes through the get
//  state. The next request is taken once the engine is back in its idle state.
//  A finished result sits in an output register, so the next request is taken
//  while the receiver stalls rsp_tready; the engine holds that request's result
//  until the register frees.
//  Reset is synchronous: all ids become unbound, the free stack empties and the
//  high-water mark returns to one. No clearing pass is needed.
module named_handle_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // name_hash[63:0], obj_value[95:64], slot_id[103:96]
   input  logic [nha_pkg::REQ_TDATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [nha_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], handle_id[9:2], value_out[41:10], high_water[50:42], zero pad
   output logic [nha_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import nha_pkg::*;

   nha_req_type req;
   nha_rsp_type res;
   logic        res_valid;
   logic        res_ready;
   nha_rsp_type rsp_ff;
   logic        rsp_valid_ff;

   // unpack request
   always_comb begin
      req.op        = nha_op_type'(req_tuser);
      req.name_hash = req_tdata[NAME_W-1:0];
      req.obj_value = req_tdata[NAME_W+VALUE_W-1:NAME_W];
      req.slot_id   = req_tdata[REQ_BITS-1:NAME_W+VALUE_W];
   end

   nha_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   // pack result
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_BITS){1'b0}}, rsp_ff.high_water,
                        rsp_ff.value_out, rsp_ff.handle_id, rsp_ff.status};

endmodule

### rtl/core/nha_checker.sv
// nha_port_checker: port-level assertions for the handle allocator, bound to the top level
// depends on nha_pkg and named_handle_allocator_top
module nha_port_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [nha_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import nha_pkg::*;

   logic [STAT_W-1:0]  st;
   logic [ID_W-1:0]    hid;
   logic [VALUE_W-1:0] vout;
   logic [CNT_W-1:0]   hw;

   assign st   = rsp_tdata[STAT_W-1:0];
   assign hid  = rsp_tdata[STAT_W+ID_W-1:STAT_W];
   assign vout = rsp_tdata[STAT_W+ID_W+VALUE_W-1:STAT_W+ID_W];
   assign hw   = rsp_tdata[RSP_BITS-1:STAT_W+ID_W+VALUE_W];

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a successful request always names a real id
   a_ok_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == STAT_OK |-> hid != '0 && hw != '0)
      else $error("ok result without an id");

   // limit only when every fresh id is spent
   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == STAT_LIMIT |-> hw == CNT_W'(MAX_IDS) && hid == '0 && vout == '0)
      else $error("limit reported with ids left");

   // a miss carries neither id nor value
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == STAT_NOT_FOUND |-> hid == '0 && vout == '0)
      else $error("not-found result carries data");

   // requests are taken one at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

endmodule

bind named_handle_allocator_top nha_port_checker u_nha_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### sim/nha_checker.sv
// nha_checker: watches both stream channels of the handle allocator, predicts every
// result from its own copy of the registry and compares it field by field
// depends on nha_pkg
module nha_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // name_hash[63:0], obj_value[95:64], slot_id[103:96]
   input  logic [nha_pkg::REQ_TDATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [nha_pkg::OP_W-1:0]        req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], handle_id[9:2], value_out[41:10], high_water[50:42], zero pad
   input  logic [nha_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                              result_count,
   output int                              fail_count
);
   import nha_pkg::*;

   // predicted registry contents
   logic [NAME_W-1:0]  slot_name  [MAX_IDS];
   bit                 slot_bound [MAX_IDS];
   logic [VALUE_W-1:0] slot_value [MAX_IDS];
   logic [ID_W-1:0]    freed_ids  [MAX_IDS];
   int unsigned        freed_depth;
   int unsigned        fresh_id;

   // results owed by the block, oldest first
   nha_rsp_type        owed_results[$];
   int                 mismatch_count;
   int                 owed_count;

   // a result still owed at the end counts as a failure
   assign fail_count = mismatch_count + owed_count;

   // id bound to a name, 0 when unbound
   function automatic int unsigned bound_id_of(logic [NAME_W-1:0] name);
      for (int i = 1; i < MAX_IDS; i++) begin
         if (slot_bound[i] && slot_name[i] == name)
            return unsigned'(i);
      end
      return 0;
   endfunction

   // update the registry for one request and return its result
   function automatic nha_rsp_type registry_update(nha_req_type req);
      nha_rsp_type r;
      int unsigned id;
      r        = '0;
      r.status = STAT_OK;
      case (req.op)
         OP_REGISTER: begin
            id = bound_id_of(req.name_hash);
            if (id != 0) begin
               r.status    = STAT_IN_USE;
               r.handle_id = ID_W'(id);
            end else begin
               // last freed id first, else a fresh one
               if (freed_depth > 0) begin
                  freed_depth--;
                  id = 32'(freed_ids[freed_depth]);
               end else if (fresh_id < MAX_IDS) begin
                  id = fresh_id;
                  fresh_id++;
               end
               if (id == 0) begin
                  r.status = STAT_LIMIT;
               end else begin
                  slot_bound[id] = 1'b1;
                  slot_name[id]  = req.name_hash;
                  slot_value[id] = req.obj_value;
                  r.handle_id    = ID_W'(id);
               end
            end
         end
         OP_UNREGISTER: begin
            id = bound_id_of(req.name_hash);
            if (id == 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               slot_bound[id] = 1'b0;
               slot_value[id] = '0;
               if (freed_depth < MAX_IDS) begin
                  freed_ids[freed_depth] = ID_W'(id);
                  freed_depth++;
               end
               r.handle_id = ID_W'(id);
            end
         end
         OP_QUERY: begin
            id = bound_id_of(req.name_hash);
            if (id == 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               r.handle_id = ID_W'(id);
               r.value_out = slot_value[id];
            end
         end
         default: begin
            // get by id: only ids handed out so far are in range
            if (req.slot_id == 0 || 32'(req.slot_id) >= fresh_id) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               r.handle_id = req.slot_id;
               r.value_out = slot_value[req.slot_id];
            end
         end
      endcase
      r.high_water = CNT_W'(fresh_id);
      return r;
   endfunction

   // predict on each accepted request, compare on each accepted result
   always @(posedge clock) begin : watch
      nha_req_type req;
      nha_rsp_type got;
      nha_rsp_type want;
      if (reset) begin
         slot_bound     = '{default: 1'b0};
         slot_value     = '{default: '0};
         freed_depth    = 0;
         fresh_id       = 1;
         mismatch_count = 0;
         owed_results.delete();
         owed_count   <= 0;
         result_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            req.op        = nha_op_type'(req_tuser);
            req.name_hash = req_tdata[63:0];
            req.obj_value = req_tdata[95:64];
            req.slot_id   = req_tdata[103:96];
            owed_results.push_back(registry_update(req));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status     = nha_status_type'(rsp_tdata[1:0]);
            got.handle_id  = rsp_tdata[9:2];
            got.value_out  = rsp_tdata[41:10];
            got.high_water = rsp_tdata[50:42];
            result_count  <= result_count + 1;
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, got);
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %s got %s", $time,
                           want.status.name(), got.status.name());
                  mismatch_count++;
               end
               if (got.handle_id !== want.handle_id) begin
                  $display("%0t: handle_id expected %0d got %0d", $time,
                           want.handle_id, got.handle_id);
                  mismatch_count++;
               end
               if (got.value_out !== want.value_out) begin
                  $display("%0t: value_out expected %h got %h", $time,
                           want.value_out, got.value_out);
                  mismatch_count++;
               end
               if (got.high_water !== want.high_water) begin
                  $display("%0t: high_water expected %0d got %0d", $time,
                           want.high_water, got.high_water);
                  mismatch_count++;
               end
            end
         end
         owed_count <= owed_results.size();
      end
   end

endmodule

### sim/named_handle_allocator_top_tb.sv
// named_handle_allocator_top_tb: drives requests into the handle allocator under
// changing idle and stall patterns and gives the verdict
// depends on nha_pkg, named_handle_allocator_top and nha_checker
module named_handle_allocator_top_tb;
   import nha_pkg::*;

   localparam int HOLD_CYCLES  = 1500;
   localparam int DRAIN_CYCLES = 300;
   localparam int POOL_SIZE    = 320;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int result_count;
   int fail_count;
   int accepted      = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // names that requests keep coming back to
   logic [NAME_W-1:0] names [POOL_SIZE];

   named_handle_allocator_top i_dut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata
   );

   nha_checker i_checker (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .result_count,
      .fail_count
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #30_000_000;
      $display("named_handle_allocator_top_tb: errors");
      $finish;
   end

   // result side: random stalls, plus a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // offer one request and wait for its handshake
   task automatic send_req(nha_op_type op, logic [NAME_W-1:0] name,
                           logic [VALUE_W-1:0] val, logic [ID_W-1:0] sid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {sid, val, name};
      // ready only moves at the rising edge, so look at it in mid cycle
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      accepted++;
   endtask

   // one random request; weights in percent, get takes the rest
   task automatic random_req(int reg_w, int unreg_w, int query_w);
      int                pick;
      nha_op_type        op;
      logic [NAME_W-1:0] name;
      logic [ID_W-1:0]   sid;
      pick = $urandom_range(99);
      if (pick < reg_w)
         op = OP_REGISTER;
      else if (pick < reg_w + unreg_w)
         op = OP_UNREGISTER;
      else if (pick < reg_w + unreg_w + query_w)
         op = OP_QUERY;
      else
         op = OP_GET;
      // mostly known names, now and then a stranger
      if ($urandom_range(9) == 0)
         name = {$urandom, $urandom};
      else
         name = names[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(1) == 0)
         sid = ID_W'($urandom_range(255));
      else
         sid = ID_W'($urandom_range(40));
      send_req(op, name, $urandom, sid);
   endtask

   // stop offering and hold back until every result is in
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (result_count != accepted) @(posedge clock);
   endtask

   task automatic run_phase(int idle, int stall, int count,
                            int reg_w, int unreg_w, int query_w);
      send_idle_pct = idle;
      stall_pct    <= stall;
      repeat (count) random_req(reg_w, unreg_w, query_w);
      wait_drained();
   endtask

   // stimulus and verdict
   initial begin
      int start;
      names[0] = '0;
      names[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         names[i] = {$urandom, $urandom};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty registry, extremes, reuse order, range of get
      send_req(OP_GET,        '0,        '0,           8'd0);
      send_req(OP_QUERY,      names[0],  '0,           8'd0);
      send_req(OP_UNREGISTER, names[0],  '0,           8'd0);
      send_req(OP_REGISTER,   names[0],  '0,           8'd0);
      send_req(OP_REGISTER,   names[1],  '1,           8'hff);
      send_req(OP_REGISTER,   names[0],  32'd5,        8'd0);
      send_req(OP_QUERY,      names[1],  '0,           8'd0);
      send_req(OP_GET,        '0,        '0,           8'd2);
      send_req(OP_GET,        '1,        '1,           8'd3);
      send_req(OP_GET,        '0,        '0,           8'd255);
      send_req(OP_REGISTER,   names[2],  32'h12345678, 8'd0);
      send_req(OP_UNREGISTER, names[0],  '0,           8'd0);
      send_req(OP_GET,        '0,        '0,           8'd1);
      send_req(OP_QUERY,      names[0],  '0,           8'd0);
      send_req(OP_UNREGISTER, names[1],  '0,           8'd0);
      send_req(OP_REGISTER,   names[3],  32'hcafe0001, 8'd0);
      send_req(OP_REGISTER,   names[4],  32'h0000beef, 8'd0);
      send_req(OP_REGISTER,   names[5],  32'h80000000, 8'd0);
      send_req(OP_GET,        '0,        '0,           8'haa);
      send_req(OP_QUERY,      names[2],  '0,           8'd0);
      send_req(OP_UNREGISTER, names[4],  '0,           8'd0);
      send_req(OP_GET,        '0,        '0,           8'd1);
      wait_drained();

      // random mix, no idling
      run_phase(0, 0, 250, 40, 20, 25);

      // fill every id and run into the limit, sender mostly idle
      send_idle_pct = 80;
      stall_pct    <= 0;
      start = $urandom_range(POOL_SIZE - 1);
      for (int i = 0; i < 300; i++)
         send_req(OP_REGISTER, names[(start + i) % POOL_SIZE], $urandom,
                  ID_W'($urandom_range(255)));
      wait_drained();

      // long receiver hold-off while requests keep coming
      send_idle_pct = 0;
      hold_asked   <= hold_asked + 1;
      repeat (20) random_req(10, 10, 50);
      wait_drained();

      // free ids and take them back, receiver mostly stalled
      run_phase(0, 80, 300, 25, 35, 25);
      // both sides idle now and then
      run_phase(14, 14, 300, 35, 25, 25);
      // back to full rate
      run_phase(0, 0, 300, 35, 25, 25);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("named_handle_allocator_top_tb: clean");
      else
         $display("named_handle_allocator_top_tb: errors");
      $finish;
   end

endmodule

### files.f
rtl/core/nha_pkg.sv
rtl/core/nha_engine.sv
rtl/core/named_handle_allocator_top.sv
rtl/core/nha_checker.sv
sim/nha_checker.sv
sim/named_handle_allocator_top_tb.sv
